// File: sv/rtc_pkg.sv
// ----------------------------------------------------------------------------
// rtc_pkg
// Shared types and token codes of the regex tokenizer.
// ----------------------------------------------------------------------------
package rtc_pkg;

    // token kinds
    localparam logic [3:0] KIND_LIT    = 4'd0;
    localparam logic [3:0] KIND_LBRACK = 4'd1;
    localparam logic [3:0] KIND_RBRACK = 4'd2;
    localparam logic [3:0] KIND_QMARK  = 4'd3;
    localparam logic [3:0] KIND_PLUS   = 4'd4;
    localparam logic [3:0] KIND_STAR   = 4'd5;
    localparam logic [3:0] KIND_BAR    = 4'd6;
    localparam logic [3:0] KIND_LPAREN = 4'd7;
    localparam logic [3:0] KIND_RPAREN = 4'd8;
    localparam logic [3:0] KIND_DOT    = 4'd9;
    localparam logic [3:0] KIND_DASH   = 4'd10;
    localparam logic [3:0] KIND_CARET  = 4'd11;
    localparam logic [3:0] KIND_CONCAT = 4'd12;
    localparam logic [3:0] KIND_NONE   = 4'd13;

    localparam logic ERR_NONE   = 1'b0;
    localparam logic ERR_ESCAPE = 1'b1;

    localparam int CMD_FIFO_DEPTH = 4;

    typedef struct packed {
        logic [7:0] in_char;
        logic       pattern_end;
    } char_item_t;

    typedef struct packed {
        logic [3:0] token_kind;
        logic [7:0] literal_value;
        logic       error_code;
        logic       pattern_done;
        logic       last_of_run;
    } token_item_t;

    // one classified character: the token plus whether a concat goes first
    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] value;
        logic       err;
        logic       concat;
        logic       done;
    } cmd_t;

endpackage

// File: sv/regex_tokenizer_with_concat.sv
// ----------------------------------------------------------------------------
// regex_tokenizer_with_concat
// Regex lexer: pattern characters in, tokens with explicit concat out.
//
//  channel  | handshake        | payload
//  ---------+------------------+---------------------------------------------
//  input    | push / full      | char_item : in_char, pattern_end
//  result   | empty / pop      | token : kind, literal, error, done, last
//
// One character is accepted per cycle while the command queue has room.
// The emitter sends one result per cycle while its output is empty or popped;
// a character that needs a concat yields a concat result, then its token.
// Reset clears the lexer state, the queue and the output stage.
// Either side may stall; the queue of FIFO_DEPTH commands decouples them.
// ----------------------------------------------------------------------------
module regex_tokenizer_with_concat
#(
    parameter int FIFO_DEPTH = rtc_pkg::CMD_FIFO_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  rtc_pkg::char_item_t  char_item,
    output logic                 empty,
    input  logic                 pop,
    output rtc_pkg::token_item_t token
);

    rtc_pkg::cmd_t wr_cmd;
    rtc_pkg::cmd_t head_cmd;
    logic          cmd_wr;
    logic          cmd_rd;
    logic          q_full;
    logic          q_empty;

    assign full = q_full;

    rtc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (q_full),
        .char_item (char_item),
        .cmd_wr    (cmd_wr),
        .cmd       (wr_cmd)
    );

    rtc_fifo
    #(
        .DEPTH (FIFO_DEPTH)
    )
    u_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_wr),
        .wr_data (wr_cmd),
        .rd_en   (cmd_rd),
        .rd_data (head_cmd),
        .full    (q_full),
        .empty   (q_empty)
    );

    rtc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (head_cmd),
        .cmd_empty (q_empty),
        .cmd_rd    (cmd_rd),
        .pop       (pop),
        .empty     (empty),
        .token     (token)
    );

endmodule

// File: sv/rtc_front.sv
// ----------------------------------------------------------------------------
// rtc_front
// Classifies each character, tracks escape/drop/previous-token state and
// writes one command per token-producing character.
// ----------------------------------------------------------------------------
module rtc_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic                full,
    input  rtc_pkg::char_item_t char_item,
    output logic                cmd_wr,
    output rtc_pkg::cmd_t       cmd
);

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_CARET  = 8'h5E;

    logic [3:0] prev_kind_reg, prev_kind_next;
    logic       esc_reg, esc_next;
    logic       drop_reg, drop_next;
    logic       accept;
    logic       emit;
    logic       wants_concat;

    assign accept = push && !full;

    always_comb
    begin
        case (prev_kind_reg)
            rtc_pkg::KIND_LIT, rtc_pkg::KIND_RBRACK, rtc_pkg::KIND_QMARK,
            rtc_pkg::KIND_PLUS, rtc_pkg::KIND_STAR, rtc_pkg::KIND_RPAREN,
            rtc_pkg::KIND_DOT: wants_concat = 1'b1;
            default:           wants_concat = 1'b0;
        endcase
    end

    always_comb
    begin
        emit       = 1'b1;
        cmd.kind   = rtc_pkg::KIND_NONE;
        cmd.value  = 8'd0;
        cmd.err    = rtc_pkg::ERR_NONE;
        cmd.concat = 1'b0;
        cmd.done   = char_item.pattern_end;
        esc_next   = esc_reg;
        drop_next  = drop_reg;

        if (drop_reg)
        begin
            emit = 1'b0;
        end
        else if (esc_reg)
        begin
            esc_next   = 1'b0;
            cmd.kind   = rtc_pkg::KIND_LIT;
            cmd.concat = wants_concat;
            case (char_item.in_char)
                CH_BSLASH: cmd.value = CH_BSLASH;
                CH_T:      cmd.value = CH_TAB;
                CH_QUOTE:  cmd.value = CH_QUOTE;
                CH_N:      cmd.value = CH_LF;
                CH_UNDER:  cmd.value = CH_SPACE;
                CH_DQUOTE: cmd.value = CH_DQUOTE;
                default:
                begin
                    cmd.kind   = rtc_pkg::KIND_NONE;
                    cmd.err    = rtc_pkg::ERR_ESCAPE;
                    cmd.concat = 1'b0;
                    drop_next  = 1'b1;
                end
            endcase
        end
        else
        begin
            case (char_item.in_char)
                CH_BSLASH:
                begin
                    // backslash as the last character is a bad escape
                    if (char_item.pattern_end)
                    begin
                        cmd.err   = rtc_pkg::ERR_ESCAPE;
                        drop_next = 1'b1;
                    end
                    else
                    begin
                        emit     = 1'b0;
                        esc_next = 1'b1;
                    end
                end
                CH_LBRACK:
                begin
                    cmd.kind   = rtc_pkg::KIND_LBRACK;
                    cmd.concat = wants_concat;
                end
                CH_RBRACK: cmd.kind = rtc_pkg::KIND_RBRACK;
                CH_QMARK:  cmd.kind = rtc_pkg::KIND_QMARK;
                CH_PLUS:   cmd.kind = rtc_pkg::KIND_PLUS;
                CH_STAR:   cmd.kind = rtc_pkg::KIND_STAR;
                CH_BAR:    cmd.kind = rtc_pkg::KIND_BAR;
                CH_LPAREN:
                begin
                    cmd.kind   = rtc_pkg::KIND_LPAREN;
                    cmd.concat = wants_concat;
                end
                CH_RPAREN: cmd.kind = rtc_pkg::KIND_RPAREN;
                CH_DOT:
                begin
                    cmd.kind   = rtc_pkg::KIND_DOT;
                    cmd.concat = wants_concat;
                end
                CH_DASH:   cmd.kind = rtc_pkg::KIND_DASH;
                CH_CARET:  cmd.kind = rtc_pkg::KIND_CARET;
                default:
                begin
                    cmd.kind   = rtc_pkg::KIND_LIT;
                    cmd.value  = char_item.in_char;
                    cmd.concat = wants_concat;
                end
            endcase
        end

        // error tokens leave the previous kind alone
        prev_kind_next = (emit && !cmd.err) ? cmd.kind : prev_kind_reg;

        if (char_item.pattern_end)
        begin
            prev_kind_next = rtc_pkg::KIND_NONE;
            esc_next       = 1'b0;
            drop_next      = 1'b0;
        end
    end

    assign cmd_wr = accept && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_kind_reg <= rtc_pkg::KIND_NONE;
            esc_reg       <= 1'b0;
            drop_reg      <= 1'b0;
        end
        else if (accept)
        begin
            prev_kind_reg <= prev_kind_next;
            esc_reg       <= esc_next;
            drop_reg      <= drop_next;
        end
    end

endmodule

// File: sv/rtc_fifo.sv
// ----------------------------------------------------------------------------
// rtc_fifo
// Small command queue between the classifier and the token emitter.
// ----------------------------------------------------------------------------
module rtc_fifo
#(
    parameter int DEPTH = rtc_pkg::CMD_FIFO_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  rtc_pkg::cmd_t wr_data,
    input  logic          rd_en,
    output rtc_pkg::cmd_t rd_data,
    output logic          full,
    output logic          empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    rtc_pkg::cmd_t    mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: sv/rtc_back.sv
// ----------------------------------------------------------------------------
// rtc_back
// Expands each command into an optional concat plus its token, one result
// per cycle while the output is empty or popped, via a registered output stage.
// ----------------------------------------------------------------------------
module rtc_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  rtc_pkg::cmd_t        cmd,
    input  logic                 cmd_empty,
    output logic                 cmd_rd,
    input  logic                 pop,
    output logic                 empty,
    output rtc_pkg::token_item_t token
);

    rtc_pkg::token_item_t out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 phase_reg, phase_next;   // concat of head already sent
    logic                 load;
    logic                 take;

    assign load  = !out_valid_reg || pop;
    assign take  = load && !cmd_empty;
    assign empty = !out_valid_reg;
    assign token = out_reg;

    always_comb
    begin
        out_next   = out_reg;
        phase_next = phase_reg;
        cmd_rd     = 1'b0;
        if (take)
        begin
            if (cmd.concat && !phase_reg)
            begin
                out_next.token_kind    = rtc_pkg::KIND_CONCAT;
                out_next.literal_value = 8'd0;
                out_next.error_code    = rtc_pkg::ERR_NONE;
                out_next.pattern_done  = 1'b0;
                out_next.last_of_run   = 1'b0;
                phase_next             = 1'b1;
            end
            else
            begin
                out_next.token_kind    = cmd.kind;
                out_next.literal_value = cmd.value;
                out_next.error_code    = cmd.err;
                out_next.pattern_done  = cmd.done;
                out_next.last_of_run   = 1'b1;
                phase_next             = 1'b0;
                cmd_rd                 = 1'b1;
            end
        end
        out_valid_next = take ? 1'b1 : (pop ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

// File: sv/rtc_checker.sv
// ----------------------------------------------------------------------------
// rtc_checker
// Port-level checks of the regex tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module rtc_checker
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 push,
    input logic                 full,
    input rtc_pkg::char_item_t  char_item,
    input logic                 empty,
    input logic                 pop,
    input rtc_pkg::token_item_t token
);

    // an offered transaction holds while the queue is full
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && full) |=> (push && $stable(char_item)))
        else $error("input changed while stalled");

    // a waiting result holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(token)))
        else $error("result changed while stalled");

    // error results carry no token
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && token.error_code) |->
        (token.token_kind == rtc_pkg::KIND_NONE && token.literal_value == 8'd0))
        else $error("error result carries a token");

    // a concat is never the last result of its run nor the pattern end
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && token.token_kind == rtc_pkg::KIND_CONCAT) |->
        (!token.last_of_run && !token.pattern_done))
        else $error("concat marked as last result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && token.pattern_done) |-> token.last_of_run)
        else $error("pattern end not on last result");

endmodule

bind regex_tokenizer_with_concat rtc_checker u_rtc_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .char_item (char_item),
    .empty     (empty),
    .pop       (pop),
    .token     (token)
);

// File: tb/tb_regex_tokenizer_with_concat.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_regex_tokenizer_with_concat
// Self-checking bench for the regex lexer. Pattern bytes go in through the
// push/full queue interface. A scoreboard class keeps its own lexer state,
// predicts the token stream (concat insertion, escapes, error drop) and checks
// every popped token in order. A directed pass covers the operators and the
// escape and error corners. Random patterns follow, run under three
// sender/receiver stall mixes.
// ----------------------------------------------------------------------------
module tb_regex_tokenizer_with_concat;

    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_QUOTE     = 8'h27;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;

    localparam int MAX_REPORTS = 10;
    localparam int DRAIN_CYCLES = 16;

    // ------------------------------------------------------------------
    // Token scoreboard: lexer state mirror plus queue of expected tokens
    // ------------------------------------------------------------------
    class token_scoreboard;
        rtc_pkg::token_item_t expected_tokens[$];
        logic [3:0]           last_kind;
        bit                   esc_wait;
        bit                   dropping;
        int                   mismatches;

        function new();
            mismatches = 0;
            clear_lexer();
        endfunction

        function void clear_lexer();
            last_kind = rtc_pkg::KIND_NONE;
            esc_wait  = 1'b0;
            dropping  = 1'b0;
        endfunction

        function int outstanding();
            return expected_tokens.size();
        endfunction

        function void add_token(logic [3:0] kind, logic [7:0] val, logic err);
            rtc_pkg::token_item_t t;
            t.token_kind    = kind;
            t.literal_value = val;
            t.error_code    = err;
            t.pattern_done  = 1'b0;
            t.last_of_run   = 1'b0;
            expected_tokens = {expected_tokens, t};
            // error tokens leave the concat context alone
            if (err == rtc_pkg::ERR_NONE)
                last_kind = kind;
        endfunction

        // token that may need a concat ahead of it
        function void add_joined(logic [3:0] kind, logic [7:0] val);
            if (last_kind inside {rtc_pkg::KIND_LIT, rtc_pkg::KIND_RBRACK,
                                  rtc_pkg::KIND_QMARK, rtc_pkg::KIND_PLUS,
                                  rtc_pkg::KIND_STAR, rtc_pkg::KIND_RPAREN,
                                  rtc_pkg::KIND_DOT})
                add_token(rtc_pkg::KIND_CONCAT, 8'h00, rtc_pkg::ERR_NONE);
            add_token(kind, val, rtc_pkg::ERR_NONE);
        endfunction

        // predicts the tokens of one accepted transaction
        function void note_char(rtc_pkg::char_item_t ci);
            int         n_before;
            logic [7:0] c;
            n_before = expected_tokens.size();
            c        = ci.in_char;
            if (dropping)
            begin
            end
            else if (esc_wait)
            begin
                esc_wait = 1'b0;
                case (c)
                    CH_BACKSLASH: add_joined(rtc_pkg::KIND_LIT, CH_BACKSLASH);
                    "t":          add_joined(rtc_pkg::KIND_LIT, CH_TAB);
                    CH_QUOTE:     add_joined(rtc_pkg::KIND_LIT, CH_QUOTE);
                    "n":          add_joined(rtc_pkg::KIND_LIT, CH_LF);
                    "_":          add_joined(rtc_pkg::KIND_LIT, CH_SPACE);
                    CH_DQUOTE:    add_joined(rtc_pkg::KIND_LIT, CH_DQUOTE);
                    default:
                    begin
                        add_token(rtc_pkg::KIND_NONE, 8'h00, rtc_pkg::ERR_ESCAPE);
                        dropping = 1'b1;
                    end
                endcase
            end
            else
            begin
                case (c)
                    CH_BACKSLASH:
                    begin
                        // a trailing backslash has no partner
                        if (ci.pattern_end)
                        begin
                            add_token(rtc_pkg::KIND_NONE, 8'h00, rtc_pkg::ERR_ESCAPE);
                            dropping = 1'b1;
                        end
                        else
                        begin
                            esc_wait = 1'b1;
                        end
                    end
                    "[":     add_joined(rtc_pkg::KIND_LBRACK, 8'h00);
                    "]":     add_token(rtc_pkg::KIND_RBRACK, 8'h00, rtc_pkg::ERR_NONE);
                    "?":     add_token(rtc_pkg::KIND_QMARK, 8'h00, rtc_pkg::ERR_NONE);
                    "+":     add_token(rtc_pkg::KIND_PLUS, 8'h00, rtc_pkg::ERR_NONE);
                    "*":     add_token(rtc_pkg::KIND_STAR, 8'h00, rtc_pkg::ERR_NONE);
                    "|":     add_token(rtc_pkg::KIND_BAR, 8'h00, rtc_pkg::ERR_NONE);
                    "(":     add_joined(rtc_pkg::KIND_LPAREN, 8'h00);
                    ")":     add_token(rtc_pkg::KIND_RPAREN, 8'h00, rtc_pkg::ERR_NONE);
                    ".":     add_joined(rtc_pkg::KIND_DOT, 8'h00);
                    "-":     add_token(rtc_pkg::KIND_DASH, 8'h00, rtc_pkg::ERR_NONE);
                    "^":     add_token(rtc_pkg::KIND_CARET, 8'h00, rtc_pkg::ERR_NONE);
                    default: add_joined(rtc_pkg::KIND_LIT, c);
                endcase
            end
            if (expected_tokens.size() > n_before)
            begin
                expected_tokens[expected_tokens.size() - 1].last_of_run = 1'b1;
                if (ci.pattern_end)
                    expected_tokens[expected_tokens.size() - 1].pattern_done = 1'b1;
            end
            if (ci.pattern_end)
                clear_lexer();
        endfunction

        function void check_token(rtc_pkg::token_item_t got);
            rtc_pkg::token_item_t want;
            if (expected_tokens.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected token kind=%0d lit=%h err=%0d done=%0d last=%0d",
                             $realtime, got.token_kind, got.literal_value, got.error_code,
                             got.pattern_done, got.last_of_run);
                return;
            end
            want = expected_tokens.pop_front();
            if (got.token_kind !== want.token_kind ||
                got.literal_value !== want.literal_value ||
                got.error_code !== want.error_code ||
                got.pattern_done !== want.pattern_done ||
                got.last_of_run !== want.last_of_run)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"%0t: token mismatch exp kind=%0d lit=%h err=%0d done=%0d ",
                              "last=%0d | got kind=%0d lit=%h err=%0d done=%0d last=%0d"},
                             $realtime, want.token_kind, want.literal_value,
                             want.error_code, want.pattern_done, want.last_of_run,
                             got.token_kind, got.literal_value, got.error_code,
                             got.pattern_done, got.last_of_run);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT and stimulus signals
    // ------------------------------------------------------------------
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 push      = 1'b0;
    logic                 pop       = 1'b0;
    rtc_pkg::char_item_t  char_item = '0;
    logic                 full;
    logic                 empty;
    rtc_pkg::token_item_t token;

    token_scoreboard sb;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          sent_chars    = 0;

    logic [7:0] meta_chars[11] = '{"[", "]", "?", "+", "*", "|", "(", ")", ".", "-", "^"};
    logic [7:0] escape_chars[6] = '{CH_BACKSLASH, "t", CH_QUOTE, "n", "_", CH_DQUOTE};

    regex_tokenizer_with_concat u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .char_item (char_item),
        .empty     (empty),
        .pop       (pop),
        .token     (token)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // result side: check each popped transaction, then pick next pop
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
                sb.check_token(token);
            pop <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Drive tasks
    // ------------------------------------------------------------------
    task automatic send_char(input logic [7:0] c, input logic last);
        rtc_pkg::char_item_t ci;
        ci.in_char     = c;
        ci.pattern_end = last;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push      <= 1'b1;
        char_item <= ci;
        do
            @(posedge clk);
        while (full);
        sb.note_char(ci);
        sent_chars++;
    endtask

    task automatic send_text(input string s, input bit ends_pattern);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], ends_pattern && (i == s.len() - 1));
    endtask

    // well-formed patterns mostly; invalid escapes and stray backslashes as noise
    task automatic send_random_pattern();
        int         len;
        int         pick;
        bit         last;
        logic [7:0] c;
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++)
        begin
            last = (i == len - 1);
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                c = meta_chars[$urandom_range(0, 10)];
            end
            else if (pick < 60)
            begin
                c = 8'($urandom_range(8'h20, 8'h7E));
            end
            else if (pick < 75)
            begin
                c = 8'($urandom_range(0, 255));
            end
            else if (pick < 93)
            begin
                send_char(CH_BACKSLASH, 1'b0);
                if ($urandom_range(0, 9) == 0)
                    c = 8'($urandom_range(0, 255));
                else
                    c = escape_chars[$urandom_range(0, 5)];
            end
            else
            begin
                c = CH_BACKSLASH;
            end
            send_char(c, last);
        end
    endtask

    task automatic wait_drained();
        while (sb.outstanding() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extreme bytes around every operator
        send_char(8'h00, 1'b0);
        send_text("([-])?+*|^.", 1'b0);
        send_char(8'hFF, 1'b1);
        // valid escapes after a literal
        send_text("x\\t\\\\\\\"", 1'b1);
        // bad escape, then a dropped byte that ends the pattern
        send_text("\\qa", 1'b1);
        // trailing backslash
        send_text("b\\", 1'b1);

        send_idle_pct = 8;
        recv_idle_pct = 47;
        while (sent_chars < 540)
            send_random_pattern();

        // hold off the sender until the result queue runs dry
        push <= 1'b0;
        wait_drained();

        send_idle_pct = 47;
        recv_idle_pct = 8;
        while (sent_chars < 1040)
            send_random_pattern();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (sent_chars < 1550)
            send_random_pattern();

        push <= 1'b0;
        wait_drained();

        if (sb.outstanding() > 0)
            $display("%0d expected tokens never arrived", sb.outstanding());
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("timeout waiting for tokens");
        $display("Simulation FAILED");
        $finish;
    end

endmodule
